@@ sv/kwm_pkg.sv @@
// Package for the k-way sorted merge: sizes, request/result codes and the
// structs passed between the lane cells and the top level.
// No dependencies.
`default_nettype none

package kwm_pkg;

  // default number of lane cells; the lane field reaches at most LaneSpan-1
  localparam int KwmLanes = 8;
  localparam int LaneSpan = 8;

  localparam int ValW  = 32;
  localparam int LaneW = 3;
  localparam int KindW = 2;
  localparam int CntW  = 4;

  localparam logic [CntW-1:0] LanesReset = 4'd8;

  // request kinds
  localparam logic [KindW-1:0] KIND_PUSH      = 2'd0;
  localparam logic [KindW-1:0] KIND_PUSH_LAST = 2'd1;
  localparam logic [KindW-1:0] KIND_END       = 2'd2;
  localparam logic [KindW-1:0] KIND_RSVD      = 2'd3;

  // result status codes
  localparam logic STATUS_EMIT    = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SEND
  } kwm_state_e;

  typedef struct packed {
    logic [KindW-1:0]       kind;
    logic [LaneW-1:0]       lane;
    logic signed [ValW-1:0] value;
  } kwm_in_t;

  typedef struct packed {
    logic                   status;
    logic signed [ValW-1:0] value_res;
    logic [LaneW-1:0]       source_lane;
    logic                   last;
  } kwm_out_t;

  // running minimum handed from cell to cell
  typedef struct packed {
    logic                   ready;
    logic                   any;
    logic                   is_final;
    logic [LaneW-1:0]       lane;
    logic signed [ValW-1:0] value;
  } kwm_tok_t;

  // command broadcast to the cells; clear is applied by all, the rest by the selected one
  typedef struct packed {
    logic                   load;
    logic                   last;
    logic                   finish;
    logic                   pop;
    logic                   clear;
    logic signed [ValW-1:0] value;
  } kwm_cmd_t;

  typedef struct packed {
    logic busy;
    logic finished;
  } kwm_stat_t;

endpackage

`default_nettype wire

@@ sv/k_way_sorted_merge.sv @@
// Top level of the k-way sorted merge: request decode, control sequencer,
// chain of lane cells and the output register.
// Depends on kwm_pkg and kwm_cell.
//
//   channel  signals                            direction
//   in       in_valid_i, in_stall_o, in_req_i   request in
//   out      out_valid_o, out_stall_i, out_res_o result out
//   cfg      cfg_we_i, cfg_wdata_i              lanes_in_use write
//
// A request is taken only in idle. A refused push goes straight to send
// and then to the output register. A push or lane end neither refused nor
// ignored runs a scan down the cell chain; each emitted element passes the
// output register and, after a lane's last element, starts another scan.
// Reset clears all lane flags and sets lanes_in_use to 8. A stalled output
// holds the request channel stalled once the pending result waits.
`default_nettype none

module k_way_sorted_merge #(
  parameter int LANES = kwm_pkg::KwmLanes
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire kwm_pkg::kwm_in_t        in_req_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output kwm_pkg::kwm_out_t            out_res_o,
  input  wire logic                    cfg_we_i,
  input  wire logic [kwm_pkg::CntW-1:0] cfg_wdata_i
);
  import kwm_pkg::*;

  localparam int LaneCap   = (LANES < LaneSpan) ? LANES : LaneSpan;
  localparam int ScanW     = $clog2(LANES + 1);

  kwm_state_e        state_q, state_d;
  logic [ScanW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]   lanes_q, eff_n;
  kwm_out_t          res_q, res_d, out_q;
  logic              again_q, again_d;
  logic              out_valid_q, out_valid_d, out_load;

  logic [LANES-1:0]  in_use_v, lane_sel_v, best_sel_v, busy_v, fin_v, sel_v;
  kwm_stat_t         stat_w [LANES];
  kwm_tok_t          tok_link [LANES+1];
  kwm_tok_t          tok_end;
  kwm_cmd_t          cmd;

  logic in_acc, ignored, busy_hit, scan_end, done;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lanes_q <= LanesReset;
    end else if (cfg_we_i) begin
      lanes_q <= cfg_wdata_i;
    end
  end

  // effective lane count
  always_comb begin
    eff_n = lanes_q;
    if (lanes_q == '0) eff_n = CntW'(1);
    else if (lanes_q > CntW'(LaneCap)) eff_n = CntW'(LaneCap);
  end

  // per-lane decode
  for (genvar i = 0; i < LANES; i++) begin : g_dec
    if (i < LaneCap) begin : g_live
      assign in_use_v[i]   = (eff_n > CntW'(i));
      assign lane_sel_v[i] = (in_req_i.lane == LaneW'(i));
      assign best_sel_v[i] = (tok_end.lane == LaneW'(i));
    end else begin : g_dead
      assign in_use_v[i]   = 1'b0;
      assign lane_sel_v[i] = 1'b0;
      assign best_sel_v[i] = 1'b0;
    end
    assign busy_v[i] = stat_w[i].busy;
    assign fin_v[i]  = stat_w[i].finished;
  end

  // chain of lane cells; the minimum enters at cell 0 empty and ready
  always_comb begin
    tok_link[0]          = '0;
    tok_link[0].ready    = 1'b1;
  end

  for (genvar i = 0; i < LANES; i++) begin : g_cell
    kwm_cell #(
      .INDEX(i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .in_use_i(in_use_v[i]),
      .sel_i   (sel_v[i]),
      .cmd_i   (cmd),
      .tok_i   (tok_link[i]),
      .tok_o   (tok_link[i+1]),
      .stat_o  (stat_w[i])
    );
  end

  assign tok_end    = tok_link[LANES];
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign ignored    = (in_req_i.kind == KIND_RSVD) || (CntW'(in_req_i.lane) >= eff_n);
  assign busy_hit   = |(busy_v & lane_sel_v);
  assign scan_end   = (state_q == ST_SCAN) && (cnt_q == ScanW'(LANES));
  assign done       = &(fin_v | ~in_use_v | (best_sel_v & {LANES{tok_end.is_final}}));
  assign out_load   = (state_q == ST_SEND) && (!out_valid_q || !out_stall_i);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && !ignored) state_d = busy_hit ? ST_SEND : ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_end) state_d = (tok_end.ready && tok_end.any) ? ST_SEND : ST_IDLE;
      end
      ST_SEND: begin
        if (out_load) state_d = again_q ? ST_SCAN : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // cell commands and pending result
  always_comb begin
    cmd       = '0;
    cmd.value = in_req_i.value;
    sel_v     = lane_sel_v;
    res_d     = res_q;
    again_d   = again_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && !ignored) begin
          if (busy_hit) begin
            res_d.status      = STATUS_REFUSED;
            res_d.value_res   = '0;
            res_d.source_lane = in_req_i.lane;
            res_d.last        = 1'b0;
            again_d           = 1'b0;
          end else begin
            cmd.load   = (in_req_i.kind != KIND_END);
            cmd.last   = (in_req_i.kind == KIND_PUSH_LAST);
            cmd.finish = (in_req_i.kind == KIND_END);
          end
        end
      end
      ST_SCAN: begin
        sel_v = best_sel_v;
        if (scan_end && tok_end.ready) begin
          if (!tok_end.any) begin
            // every lane ended empty
            cmd.clear = 1'b1;
          end else begin
            cmd.pop           = 1'b1;
            cmd.clear         = done;
            res_d.status      = STATUS_EMIT;
            res_d.value_res   = tok_end.value;
            res_d.source_lane = tok_end.lane;
            res_d.last        = done;
            again_d           = tok_end.is_final && !done;
          end
        end
      end
      ST_SEND: ;
      default: ;
    endcase
  end

  assign cnt_d       = (state_q == ST_SCAN) ? cnt_q + ScanW'(1) : '0;
  assign out_valid_d = out_load ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      again_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      again_q     <= again_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (out_load) out_q <= res_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

`ifndef SYNTH
  // refused push goes straight to the output stage
  a_refuse_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !ignored && busy_hit) |=> (state_q == ST_SEND))
    else $error("refused request did not go to send");

  // the merge-final element never triggers another scan
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && res_q.last) |=> (state_q == ST_IDLE))
    else $error("scan after last element");

  // a popped head comes from a lane in use
  a_pop_in_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (scan_end && tok_end.ready && tok_end.any) |-> (|(best_sel_v & in_use_v)))
    else $error("popped lane not in use");

  // scan counter stays within the chain length
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (cnt_q <= ScanW'(LANES)))
    else $error("scan counter overrun");
`endif

endmodule

`default_nettype wire

@@ sv/kwm_cell.sv @@
// One lane cell of the merge chain: holds the lane head and its flags and
// folds its head into the running minimum passed down the chain.
// Depends on kwm_pkg.
`default_nettype none

module kwm_cell #(
  parameter int INDEX = 0
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_use_i,
  input  wire logic              sel_i,
  input  wire kwm_pkg::kwm_cmd_t cmd_i,
  input  wire kwm_pkg::kwm_tok_t tok_i,
  output kwm_pkg::kwm_tok_t      tok_o,
  output kwm_pkg::kwm_stat_t     stat_o
);
  import kwm_pkg::*;

  logic signed [ValW-1:0] value_q;
  logic                   present_q, present_d;
  logic                   final_q, final_d;
  logic                   finished_q, finished_d;
  kwm_tok_t               tok_d, tok_q;

  // flag updates, clear wins over everything
  always_comb begin
    present_d  = present_q;
    final_d    = final_q;
    finished_d = finished_q;
    priority if (cmd_i.clear) begin
      present_d  = 1'b0;
      final_d    = 1'b0;
      finished_d = 1'b0;
    end else if (sel_i && cmd_i.load) begin
      present_d = 1'b1;
      final_d   = cmd_i.last;
    end else if (sel_i && cmd_i.finish) begin
      finished_d = 1'b1;
    end else if (sel_i && cmd_i.pop) begin
      present_d = 1'b0;
      if (final_q) finished_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q  <= 1'b0;
      final_q    <= 1'b0;
      finished_q <= 1'b0;
    end else begin
      present_q  <= present_d;
      final_q    <= final_d;
      finished_q <= finished_d;
    end
  end

  // head value, only read while present
  always_ff @(posedge clk_i) begin
    if (sel_i && cmd_i.load) value_q <= cmd_i.value;
  end

  // fold own head into the incoming minimum; strict less keeps lower lane
  always_comb begin
    tok_d = tok_i;
    if (in_use_i) begin
      if (!present_q && !finished_q) tok_d.ready = 1'b0;
      if (present_q && (!tok_i.any || (value_q < tok_i.value))) begin
        tok_d.any      = 1'b1;
        tok_d.is_final = final_q;
        tok_d.lane     = LaneW'(INDEX);
        tok_d.value    = value_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  assign tok_o           = tok_q;
  assign stat_o.busy     = present_q | finished_q;
  assign stat_o.finished = finished_q;

endmodule

`default_nettype wire
